@@ src/cft_pkg.sv @@
// Shared types and constants for the CSV field tokenizer.
// No dependencies; cft_front, cft_back and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package cft_pkg;

    // Character codes the scanner reacts to.
    localparam logic [7:0] CH_EOD   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    // Default depth of the trailing-whitespace hold.
    localparam int HOLD_DEPTH_DEF = 16;

    // Depth of the command queue between front and back.
    localparam int CMD_FIFO_DEPTH = 4;

    // Saturation limits of the counters.
    localparam logic [15:0] LINES_MAX  = 16'hFFFF;
    localparam logic [7:0]  FIELDS_MAX = 8'hFF;

    typedef enum logic [1:0] {
        MODE_DATA   = 2'd0,
        MODE_QUOTED = 2'd1,
        MODE_QSEEN  = 2'd2
    } t_parse_mode;

    typedef enum logic {
        PH_QUOTE = 1'b0,
        PH_WS    = 1'b1
    } t_back_phase;

    // One result record as it leaves the block.
    typedef struct packed {
        logic [7:0]  widest_line;
        logic [15:0] line_total;
        logic        hold_overflow;
        logic        doc_end;
        logic        line_end;
        logic        field_end;
        logic        byte_valid;
        logic [7:0]  out_byte;
    } t_result;

endpackage

`default_nettype wire

@@ src/cft_cmd_fifo.sv @@
// Small command queue that decouples the tokenizer front from its back.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module cft_cmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (do_pop && !do_push) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
    end

endmodule

`default_nettype wire

@@ src/cft_front.sv @@
// Front end of the tokenizer: scans raw bytes, keeps parse and hold state,
// and turns each byte into at most one command. Uses cft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cft_front #(
    parameter int HOLD_DEPTH = cft_pkg::HOLD_DEPTH_DEF,
    parameter int CMD_W      = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [7:0]       i_byte,
    output logic                  o_cmd_push,
    output logic [CMD_W-1:0]      o_cmd,
    input  wire logic             i_cmd_full
);

    import cft_pkg::*;

    localparam int CW = $clog2(HOLD_DEPTH + 1);
    localparam int IW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

    t_parse_mode           r_mode, n_mode;
    logic                  r_started, n_started;
    logic                  r_quoted, n_quoted;
    logic                  r_prevq, n_prevq;
    logic                  r_qheld, n_qheld;
    logic [CW-1:0]         r_count, n_count;
    logic [HOLD_DEPTH-1:0] r_tabs, n_tabs;
    logic [7:0]            r_fil, n_fil;
    logic [7:0]            r_max, n_max;
    logic [15:0]           r_lines, n_lines;

    logic          accept;
    logic          is_ws, is_q, is_tab;
    logic          raw, sep, qdoc;
    logic          cmd_q, cmd_fovf, cmd_tail_en;
    logic [CW-1:0] cmd_cnt;
    t_result       cmd_tail;
    logic [15:0]   lines_inc;
    logic [7:0]    fil_inc;
    logic [7:0]    max_new;

    assign o_ready = !i_cmd_full;
    assign accept  = i_valid && !i_cmd_full;
    assign is_q    = (i_byte == CH_QUOTE);
    assign is_tab  = (i_byte == CH_TAB);
    assign is_ws   = (i_byte == CH_SPACE) || is_tab;

    assign lines_inc = (r_lines != LINES_MAX) ? 16'(r_lines + 1'b1) : r_lines;
    assign fil_inc   = (r_fil != FIELDS_MAX) ? 8'(r_fil + 1'b1) : r_fil;
    assign max_new   = (fil_inc > r_max) ? fil_inc : r_max;

    // Mode scanner: find separators, raw field bytes and a document end inside quotes.
    always_comb begin
        n_mode = r_mode;
        raw    = 1'b0;
        sep    = 1'b0;
        qdoc   = 1'b0;
        case (r_mode)
            MODE_QUOTED: begin
                if (is_q) begin
                    n_mode = MODE_QSEEN;
                    raw    = 1'b1;
                end else if (i_byte == CH_EOD) begin
                    n_mode = MODE_DATA;
                    qdoc   = 1'b1;
                end else begin
                    raw = 1'b1;
                end
            end
            default: begin
                if (r_mode == MODE_QSEEN && is_q) begin
                    n_mode = MODE_QUOTED;
                    raw    = 1'b1;
                end else if (is_q) begin
                    n_mode = MODE_QUOTED;
                    raw    = 1'b1;
                end else begin
                    n_mode = MODE_DATA;
                    if (i_byte == CH_EOD || i_byte == CH_NL || i_byte == CH_COMMA) begin
                        sep = 1'b1;
                    end else begin
                        raw = 1'b1;
                    end
                end
            end
        endcase
    end

    always_comb begin
        n_started   = r_started;
        n_quoted    = r_quoted;
        n_prevq     = r_prevq;
        n_qheld     = r_qheld;
        n_count     = r_count;
        n_tabs      = r_tabs;
        n_fil       = r_fil;
        n_max       = r_max;
        n_lines     = r_lines;
        cmd_q       = 1'b0;
        cmd_fovf    = 1'b0;
        cmd_cnt     = '0;
        cmd_tail_en = 1'b0;
        cmd_tail    = '0;

        if (raw) begin
            n_prevq = is_q;
            if (!r_started) begin
                if (is_q) begin
                    n_quoted = 1'b1;
                end else if (!is_ws) begin
                    cmd_tail_en         = 1'b1;
                    cmd_tail.out_byte   = i_byte;
                    cmd_tail.byte_valid = 1'b1;
                    n_started           = 1'b1;
                end
            end else if (is_q && r_prevq) begin
                // Second quote of an escaped pair is dropped.
            end else if (is_ws) begin
                if (r_count == CW'(HOLD_DEPTH)) begin
                    // Hold full: push out any held quote and the oldest entry.
                    cmd_q    = r_qheld;
                    cmd_fovf = 1'b1;
                    cmd_cnt  = CW'(1);
                    n_qheld  = 1'b0;
                    n_tabs   = r_tabs >> 1;
                    n_tabs[HOLD_DEPTH-1] = is_tab;
                end else begin
                    n_tabs[r_count[IW-1:0]] = is_tab;
                    n_count = CW'(r_count + 1'b1);
                end
            end else if (is_q && r_quoted) begin
                cmd_q   = r_qheld;
                cmd_cnt = r_count;
                n_qheld = 1'b1;
                n_count = '0;
            end else begin
                cmd_q               = r_qheld;
                cmd_cnt             = r_count;
                cmd_tail_en         = 1'b1;
                cmd_tail.out_byte   = i_byte;
                cmd_tail.byte_valid = 1'b1;
                n_qheld             = 1'b0;
                n_count             = '0;
            end
        end else if (sep) begin
            n_started          = 1'b0;
            n_quoted           = 1'b0;
            n_prevq            = 1'b0;
            n_qheld            = 1'b0;
            n_count            = '0;
            n_max              = max_new;
            cmd_tail_en        = 1'b1;
            cmd_tail.field_end = 1'b1;
            if (i_byte == CH_COMMA) begin
                n_fil = fil_inc;
            end else begin
                cmd_tail.line_end = 1'b1;
                n_lines           = lines_inc;
                n_fil             = '0;
            end
            if (i_byte == CH_EOD) begin
                cmd_tail.doc_end     = 1'b1;
                cmd_tail.line_total  = lines_inc;
                cmd_tail.widest_line = max_new;
                n_fil   = '0;
                n_max   = '0;
                n_lines = '0;
            end
        end else if (qdoc) begin
            // Document ends inside quotes: unfinished field is not counted.
            cmd_tail_en          = 1'b1;
            cmd_tail.line_end    = 1'b1;
            cmd_tail.doc_end     = 1'b1;
            cmd_tail.line_total  = lines_inc;
            cmd_tail.widest_line = r_max;
            n_started = 1'b0;
            n_quoted  = 1'b0;
            n_prevq   = 1'b0;
            n_qheld   = 1'b0;
            n_count   = '0;
            n_fil     = '0;
            n_max     = '0;
            n_lines   = '0;
        end
    end

    assign o_cmd_push = accept && (cmd_q || (cmd_cnt != '0) || cmd_tail_en);
    assign o_cmd      = CMD_W'({cmd_q, cmd_fovf, cmd_cnt, r_tabs, cmd_tail_en, cmd_tail});

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tabs <= n_tabs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_DATA;
            r_started <= 1'b0;
            r_quoted  <= 1'b0;
            r_prevq   <= 1'b0;
            r_qheld   <= 1'b0;
            r_count   <= '0;
            r_fil     <= '0;
            r_max     <= '0;
            r_lines   <= '0;
        end else if (accept) begin
            r_mode    <= n_mode;
            r_started <= n_started;
            r_quoted  <= n_quoted;
            r_prevq   <= n_prevq;
            r_qheld   <= n_qheld;
            r_count   <= n_count;
            r_fil     <= n_fil;
            r_max     <= n_max;
            r_lines   <= n_lines;
        end
    end

endmodule

`default_nettype wire

@@ src/cft_back.sv @@
// Back end of the tokenizer, uses cft_pkg: expands one command into its result
// records, one per cycle while i_ready is high, into a registered output stage.
`timescale 1ns / 1ps
`default_nettype none

module cft_back #(
    parameter int HOLD_DEPTH = cft_pkg::HOLD_DEPTH_DEF,
    parameter int CMD_W      = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cmd_valid,
    input  wire logic [CMD_W-1:0] i_cmd,
    output logic                  o_cmd_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output cft_pkg::t_result      o_res,
    output logic                  o_last
);

    import cft_pkg::*;

    localparam int CW    = $clog2(HOLD_DEPTH + 1);
    localparam int IW    = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int RES_W = $bits(t_result);

    t_back_phase           r_phase, n_phase;
    logic [CW-1:0]         r_idx, n_idx;
    logic                  r_valid;
    t_result               r_res;
    logic                  r_last;

    t_result               tail;
    logic                  tail_en;
    logic [HOLD_DEPTH-1:0] tabs;
    logic [CW-1:0]         cnt;
    logic                  fovf;
    logic                  cq;
    logic                  load;
    logic                  sel_quote;
    t_result               cur_res;
    logic                  cur_last;

    assign tail    = t_result'(i_cmd[RES_W-1:0]);
    assign tail_en = i_cmd[RES_W];
    assign tabs    = i_cmd[RES_W+1 +: HOLD_DEPTH];
    assign cnt     = i_cmd[RES_W+1+HOLD_DEPTH +: CW];
    assign fovf    = i_cmd[RES_W+1+HOLD_DEPTH+CW];
    assign cq      = i_cmd[RES_W+2+HOLD_DEPTH+CW];

    assign load      = i_cmd_valid && (!r_valid || i_ready);
    assign o_cmd_pop = load && cur_last;

    // Record selection: held quote first, then held whitespace, then the tail.
    always_comb begin
        cur_res   = '0;
        cur_last  = 1'b0;
        sel_quote = 1'b0;
        case (r_phase)
            PH_QUOTE: sel_quote = cq;
            PH_WS:    sel_quote = 1'b0;
            default:  sel_quote = 1'b0;
        endcase
        if (sel_quote) begin
            cur_res.out_byte      = CH_QUOTE;
            cur_res.byte_valid    = 1'b1;
            cur_res.hold_overflow = fovf;
            cur_last              = (cnt == '0) && !tail_en;
        end else if (r_idx < cnt) begin
            cur_res.out_byte      = tabs[r_idx[IW-1:0]] ? CH_TAB : CH_SPACE;
            cur_res.byte_valid    = 1'b1;
            cur_res.hold_overflow = fovf;
            cur_last              = (CW'(r_idx + 1'b1) == cnt) && !tail_en;
        end else begin
            cur_res  = tail;
            cur_last = 1'b1;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        if (load) begin
            if (cur_last) begin
                n_phase = PH_QUOTE;
                n_idx   = '0;
            end else if (sel_quote) begin
                n_phase = PH_WS;
                n_idx   = '0;
            end else begin
                n_phase = PH_WS;
                n_idx   = CW'(r_idx + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res  <= cur_res;
            r_last <= cur_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_QUOTE;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_last  = r_last;

endmodule

`default_nettype wire

@@ src/csv_field_tokenizer.sv @@
// Top level of the streaming CSV field tokenizer: front scanner, command
// queue and result expander. Depends on cft_pkg, cft_front, cft_cmd_fifo, cft_back.
//
// The slave stream carries one raw document byte per request in s_axis_tdata;
// byte 0 closes the document and all parse state returns to its reset values.
// The master stream carries result records: tdata holds the decoded byte,
// the line count and the widest line, tuser holds the flags, and tlast marks
// the final record that a given input byte produced. A byte may produce no
// record at all (leading blanks, dropped quotes, held trailing blanks) or up
// to HOLD_DEPTH + 2 records when a held run of blanks is released.
// Throughput: the front takes one byte per cycle as long as the command queue
// has room; the back emits one record per cycle while the receiver is ready,
// so the queue absorbs the burst when a byte releases k records.
// With the queue and the output register empty, a byte's command is written
// into the queue when the byte is taken, and its first record is then loaded
// into the output register, from which it is visible.
// Reset is synchronous and active low; it empties the queue and the output
// register. No clearing pass is needed; the hold contents are only read below
// the hold count. When the receiver stalls, the output register holds its
// record, the queue fills, and s_axis_tready falls once the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module csv_field_tokenizer #(
    parameter int HOLD_DEPTH = cft_pkg::HOLD_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [7:0] out_byte, [23:8] line_total,
                                             // [31:24] widest_line
    output logic [4:0]       m_axis_tuser,   // [0] byte_valid, [1] field_end,
                                             // [2] line_end, [3] doc_end,
                                             // [4] hold_overflow
    output logic             m_axis_tlast
);

    import cft_pkg::*;

    localparam int CW    = $clog2(HOLD_DEPTH + 1);
    localparam int CMD_W = 2 + CW + HOLD_DEPTH + 1 + $bits(t_result);

    logic             cmd_push;
    logic [CMD_W-1:0] cmd_in;
    logic             cmd_full;
    logic             cmd_pop;
    logic             cmd_valid;
    logic [CMD_W-1:0] cmd_out;
    t_result          res;

    cft_front #(
        .HOLD_DEPTH (HOLD_DEPTH),
        .CMD_W      (CMD_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_byte     (s_axis_tdata),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full)
    );

    cft_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_data  (cmd_out)
    );

    cft_back #(
        .HOLD_DEPTH (HOLD_DEPTH),
        .CMD_W      (CMD_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_res       (res),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {res.widest_line, res.line_total, res.out_byte};
    assign m_axis_tuser = {res.hold_overflow, res.doc_end, res.line_end,
                           res.field_end, res.byte_valid};

    // A document end always closes a line and is the final record of its byte.
    a_doc_end_closes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tuser[2] && m_axis_tlast)
        else $error("doc_end without line_end or tlast");

    // A record is either a field byte or an end mark, never both.
    a_byte_or_mark : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && (m_axis_tuser[1] || m_axis_tuser[2])))
        else $error("field byte carries an end mark");

    // An early-released hold byte is a field byte and never ends its burst
    // with an end mark.
    a_overflow_is_byte : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[4] |-> m_axis_tuser[0] && !m_axis_tuser[3])
        else $error("hold_overflow on a record without a byte");

endmodule

`default_nettype wire
